// ===== rtl/rgbfe_pkg.sv =====
// Shared types and constants for the RGB LED frame editor.
`default_nettype none
package rgbfe_pkg;

  localparam int OPCODE_W = 2;
  localparam int BYTE_W   = 8;

  localparam logic [OPCODE_W-1:0] OP_SAMPLE   = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_COMMIT   = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_NEXT_LED = 2'd2;

  localparam int BRIGHT_W = 5;
  localparam int MASK_W   = 3;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 5;
  localparam logic [CFG_INDEX_W-1:0] CFG_GLOBAL_BRIGHTNESS = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LED_ENABLE_MASK   = 1'd1;

  localparam logic [BRIGHT_W-1:0] BRIGHT_RESET = 5'd1;
  localparam logic [MASK_W-1:0]   MASK_RESET   = 3'h7;

  localparam int NUM_CHANNELS = 3;
  localparam int CH_W         = 2;
  localparam int START_LEN    = 4;
  localparam int END_LEN      = 4;

  localparam logic [BYTE_W-1:0] START_BYTE = 8'h00;
  localparam logic [BYTE_W-1:0] END_BYTE   = 8'hFF;
  localparam logic [BYTE_W-1:0] LED_HDR    = 8'hE0;

  typedef enum logic [1:0] {
    CMD_SAMPLE   = 2'd0,
    CMD_COMMIT   = 2'd1,
    CMD_NEXT_LED = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [BYTE_W-1:0]  sample;
  } cmd_t;

endpackage
`default_nettype wire

// ===== rtl/rgbfe_if.sv =====
// Handshake channels: command items in, frame byte items out.
`default_nettype none
interface rgbfe_in_if;
  logic                           valid;
  logic                           ready;
  logic [rgbfe_pkg::OPCODE_W-1:0] opcode;
  logic [rgbfe_pkg::BYTE_W-1:0]   sample_value;

  modport source (output valid, output opcode, output sample_value, input ready);
  modport sink   (input valid, input opcode, input sample_value, output ready);
endinterface

interface rgbfe_out_if;
  logic                         valid;
  logic                         ready;
  logic [rgbfe_pkg::BYTE_W-1:0] frame_byte;
  logic                         last_of_frame;

  modport source (output valid, output frame_byte, output last_of_frame, input ready);
  modport sink   (input valid, input frame_byte, input last_of_frame, output ready);
endinterface
`default_nettype wire

// ===== rtl/rgb_led_frame_editor_top.sv =====
// Top level: APA102-style frame editor; front decoder, command queue, back end.
// Sample item: queued, decoded, then one registered frame byte per cycle unless strip stalls.
// A frame is 8 + 4*NUM_LEDS bytes (20 at default); a sample item holds the back end in its
// frame state until the last byte is registered for output, and no command is popped meanwhile.
// Commit and next-LED items are done in the back end's idle state; two commands can wait in the queue.
// Reset (rst, synchronous) clears the colour store, selection and sample, and sets brightness
// to 1 and the enable mask to all on.
`default_nettype none
module rgb_led_frame_editor_top #(
  parameter int NUM_LEDS = 3
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [rgbfe_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rgbfe_pkg::CFG_DATA_W-1:0]  cfg_data,
  rgbfe_in_if.sink                          ctrl,
  rgbfe_out_if.source                       strip
);

  logic            fe_valid;
  rgbfe_pkg::cmd_t fe_cmd;
  logic            q_not_full;
  logic            q_pop;
  rgbfe_pkg::cmd_t q_cmd;
  logic            q_not_empty;

  rgbfe_front u_front (
    .ctrl      (ctrl),
    .cmd_valid (fe_valid),
    .cmd       (fe_cmd),
    .cmd_ready (q_not_full)
  );

  rgbfe_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (fe_valid),
    .push_cmd  (fe_cmd),
    .not_full  (q_not_full),
    .pop       (q_pop),
    .head_cmd  (q_cmd),
    .not_empty (q_not_empty)
  );

  rgbfe_back #(
    .NUM_LEDS (NUM_LEDS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_valid (q_not_empty),
    .cmd       (q_cmd),
    .cmd_pop   (q_pop),
    .strip     (strip)
  );

endmodule
`default_nettype wire

// ===== rtl/rgbfe_front.sv =====
// Front end: accepts items and decodes the opcode into a command.
`default_nettype none
module rgbfe_front (
  rgbfe_in_if.sink          ctrl,
  output logic              cmd_valid,
  output rgbfe_pkg::cmd_t   cmd,
  input  logic              cmd_ready
);

  logic known_op;

  always_comb begin
    cmd.sample = ctrl.sample_value;
    known_op   = 1'b1;
    unique case (ctrl.opcode)
      rgbfe_pkg::OP_SAMPLE:   cmd.kind = rgbfe_pkg::CMD_SAMPLE;
      rgbfe_pkg::OP_COMMIT:   cmd.kind = rgbfe_pkg::CMD_COMMIT;
      rgbfe_pkg::OP_NEXT_LED: cmd.kind = rgbfe_pkg::CMD_NEXT_LED;
      default: begin
        // unused opcode: item is taken and dropped
        cmd.kind = rgbfe_pkg::CMD_SAMPLE;
        known_op = 1'b0;
      end
    endcase
  end

  assign ctrl.ready = cmd_ready;
  assign cmd_valid  = ctrl.valid && known_op;

endmodule
`default_nettype wire

// ===== rtl/rgbfe_queue.sv =====
// Two-entry command queue between front and back end.
`default_nettype none
module rgbfe_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  rgbfe_pkg::cmd_t push_cmd,
  output logic            not_full,
  input  logic            pop,
  output rgbfe_pkg::cmd_t head_cmd,
  output logic            not_empty
);

  localparam int DEPTH = 2;

  rgbfe_pkg::cmd_t entries [DEPTH];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;
  logic            do_push;
  logic            do_pop;

  assign not_full  = (count != 2'(DEPTH));
  assign not_empty = (count != 2'd0);
  assign do_push   = push && not_full;
  assign do_pop    = pop && not_empty;
  assign head_cmd  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop)  rd_ptr <= ~rd_ptr;
      priority if (do_push && !do_pop) count <= count + 2'd1;
      else if (do_pop && !do_push)     count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_cmd;
  end

endmodule
`default_nettype wire

// ===== rtl/rgbfe_back.sv =====
// Back end: colour store, selection state, config registers and frame serialiser.
`default_nettype none
module rgbfe_back #(
  parameter int NUM_LEDS = 3
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [rgbfe_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rgbfe_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                              cmd_valid,
  input  rgbfe_pkg::cmd_t                   cmd,
  output logic                              cmd_pop,
  rgbfe_out_if.source                       strip
);

  localparam int FRAME_LEN = rgbfe_pkg::START_LEN + rgbfe_pkg::END_LEN + 4 * NUM_LEDS;
  localparam int POS_W     = $clog2(FRAME_LEN);
  localparam int LED_W     = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
  localparam int BYTE_W    = rgbfe_pkg::BYTE_W;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_FRAME = 2'b10
  } state_t;

  state_t                           state;
  logic [POS_W-1:0]                 pos;
  logic [BYTE_W-1:0]                color_store [NUM_LEDS][rgbfe_pkg::NUM_CHANNELS];
  logic [LED_W-1:0]                 selected_led;
  logic [rgbfe_pkg::CH_W-1:0]       selected_channel;
  logic [BYTE_W-1:0]                last_sample;
  logic [rgbfe_pkg::BRIGHT_W-1:0]   global_brightness;
  logic [rgbfe_pkg::MASK_W-1:0]     led_enable_mask;

  logic                             out_valid;
  logic [BYTE_W-1:0]                out_byte;
  logic                             out_last;
  logic                             advance;

  logic [POS_W-1:0]                 led_pos;
  logic [LED_W-1:0]                 led_rd;
  logic [1:0]                       sub;
  logic [rgbfe_pkg::CH_W-1:0]       ch_rd;
  logic [7:0]                       mask_ext;
  logic [BYTE_W-1:0]                chan_byte;
  logic [BYTE_W-1:0]                hdr_byte;
  logic [BYTE_W-1:0]                byte_next;
  logic                             last_next;

  assign strip.valid         = out_valid;
  assign strip.frame_byte    = out_byte;
  assign strip.last_of_frame = out_last;

  assign advance = !out_valid || strip.ready;
  assign cmd_pop = (state == ST_IDLE) && cmd_valid;

  // byte for the current frame position
  always_comb begin
    led_pos  = pos - POS_W'(rgbfe_pkg::START_LEN);
    led_rd   = LED_W'(led_pos >> 2);
    sub      = led_pos[1:0];
    // sub 1..3 map to blue, green, red
    ch_rd    = (sub == 2'd0) ? 2'd0 : 2'd3 - sub;
    mask_ext = {5'd0, led_enable_mask};
    if (led_rd == selected_led && ch_rd == selected_channel) chan_byte = last_sample;
    else chan_byte = color_store[led_rd][ch_rd];
    hdr_byte = rgbfe_pkg::LED_HDR |
               (mask_ext[3'(led_rd)] ? {3'd0, global_brightness} : 8'd0);
    last_next = (pos == POS_W'(FRAME_LEN - 1));
    priority if (pos < POS_W'(rgbfe_pkg::START_LEN)) byte_next = rgbfe_pkg::START_BYTE;
    else if (pos >= POS_W'(rgbfe_pkg::START_LEN + 4 * NUM_LEDS)) byte_next = rgbfe_pkg::END_BYTE;
    else if (sub == 2'd0) byte_next = hdr_byte;
    else byte_next = chan_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      pos               <= '0;
      out_valid         <= 1'b0;
      selected_led      <= '0;
      selected_channel  <= '0;
      last_sample       <= '0;
      global_brightness <= rgbfe_pkg::BRIGHT_RESET;
      led_enable_mask   <= rgbfe_pkg::MASK_RESET;
      for (int i = 0; i < NUM_LEDS; i++) begin
        for (int k = 0; k < rgbfe_pkg::NUM_CHANNELS; k++) begin
          color_store[i][k] <= '0;
        end
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          rgbfe_pkg::CFG_GLOBAL_BRIGHTNESS: global_brightness <= cfg_data;
          rgbfe_pkg::CFG_LED_ENABLE_MASK:   led_enable_mask   <= cfg_data[rgbfe_pkg::MASK_W-1:0];
          default: ;
        endcase
      end

      if (advance) out_valid <= (state == ST_FRAME);

      unique case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            unique case (cmd.kind)
              rgbfe_pkg::CMD_SAMPLE: begin
                last_sample <= cmd.sample;
                pos         <= '0;
                state       <= ST_FRAME;
              end
              rgbfe_pkg::CMD_COMMIT: begin
                color_store[selected_led][selected_channel] <= last_sample;
                selected_channel <= (selected_channel == 2'(rgbfe_pkg::NUM_CHANNELS - 1)) ?
                                    '0 : selected_channel + 2'd1;
              end
              rgbfe_pkg::CMD_NEXT_LED: begin
                selected_led <= (selected_led == LED_W'(NUM_LEDS - 1)) ?
                                '0 : selected_led + LED_W'(1);
              end
              default: ;
            endcase
          end
        end
        ST_FRAME: begin
          if (advance) begin
            pos <= pos + POS_W'(1);
            if (last_next) state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FRAME && advance) begin
      out_byte <= byte_next;
      out_last <= last_next;
    end
  end

endmodule
`default_nettype wire
